### design/abbc_pkg.sv
package abbc_pkg;

    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_ALPHA_SRC = 2'd2;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [23:0] rgb;
        logic [7:0]  alpha;
        logic [11:0] left;
        logic [11:0] top;
        logic [12:0] width;
        logic [12:0] height;
        logic        empty;
        logic        last;
    } t_job;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_qstat;

endpackage

### design/abbc_front.sv
module abbc_front import abbc_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_accept,
    input  logic [31:0] i_pixel_argb,
    input  logic [7:0]  i_alpha_sample,
    input  logic        i_pass_index,
    output logic        o_push,
    output t_job        o_job
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = $clog2(MAX_DIM);

    function automatic logic [DW-1:0] clamp_dim(input logic [12:0] v);
        if (v == 13'd0) begin
            return DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    logic [DW-1:0] r_w, r_h;
    logic          r_src;
    logic [PW-1:0] r_col, r_row;
    logic [DW-1:0] r_min_col, r_min_row;
    logic [PW-1:0] r_max_col, r_max_row;

    logic [DW-1:0] n_min_col, n_min_row, base_min_col, base_min_row;
    logic [PW-1:0] n_max_col, n_max_row, base_max_col, base_max_row;
    logic [DW-1:0] diff_w, diff_h;
    logic [7:0]    alpha;
    logic          row_end, frame_end, origin, hit, empty, in_box;

    always_comb begin
        alpha     = r_src ? i_alpha_sample : i_pixel_argb[31:24];
        row_end   = ((DW+1)'(r_col) + (DW+1)'(1)) >= (DW+1)'(r_w);
        frame_end = row_end && (((DW+1)'(r_row) + (DW+1)'(1)) >= (DW+1)'(r_h));
        origin    = (r_col == '0) && (r_row == '0);
        hit       = (alpha != 8'd0);

        base_min_col = origin ? r_w : r_min_col;
        base_min_row = origin ? r_h : r_min_row;
        base_max_col = origin ? '0 : r_max_col;
        base_max_row = origin ? '0 : r_max_row;

        n_min_col = (hit && (DW'(r_col) < base_min_col)) ? DW'(r_col) : base_min_col;
        n_min_row = (hit && (DW'(r_row) < base_min_row)) ? DW'(r_row) : base_min_row;
        n_max_col = (hit && (r_col > base_max_col)) ? r_col : base_max_col;
        n_max_row = (hit && (r_row > base_max_row)) ? r_row : base_max_row;

        empty  = (DW'(n_max_col) < n_min_col) || (DW'(n_max_row) < n_min_row);
        diff_w = DW'(n_max_col) - n_min_col + DW'(1);
        diff_h = DW'(n_max_row) - n_min_row + DW'(1);

        in_box = (DW'(r_col) >= r_min_col) && (r_col <= r_max_col) &&
                 (DW'(r_row) >= r_min_row) && (r_row <= r_max_row);

        o_job.kind   = i_pass_index ? KIND_PIXEL : KIND_REPORT;
        o_job.rgb    = i_pixel_argb[23:0];
        o_job.alpha  = alpha;
        o_job.left   = empty ? 12'd0 : 12'(n_min_col);
        o_job.top    = empty ? 12'd0 : 12'(n_min_row);
        o_job.width  = empty ? 13'd0 : 13'(diff_w);
        o_job.height = empty ? 13'd0 : 13'(diff_h);
        o_job.empty  = empty;
        o_job.last   = (r_col == r_max_col) && (r_row == r_max_row);

        o_push = i_accept && (i_pass_index ? in_box : frame_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= DW'(1);
            r_h       <= DW'(1);
            r_src     <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= DW'(1);
            r_min_row <= DW'(1);
            r_max_col <= '0;
            r_max_row <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH: begin
                    r_w       <= clamp_dim(i_cfg_data);
                    r_col     <= '0;
                    r_row     <= '0;
                    r_min_col <= clamp_dim(i_cfg_data);
                    r_min_row <= r_h;
                    r_max_col <= '0;
                    r_max_row <= '0;
                end
                CFG_HEIGHT: begin
                    r_h       <= clamp_dim(i_cfg_data);
                    r_col     <= '0;
                    r_row     <= '0;
                    r_min_col <= r_w;
                    r_min_row <= clamp_dim(i_cfg_data);
                    r_max_col <= '0;
                    r_max_row <= '0;
                end
                CFG_ALPHA_SRC: begin
                    r_src <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (!i_pass_index) begin
                r_min_col <= n_min_col;
                r_min_row <= n_min_row;
                r_max_col <= n_max_col;
                r_max_row <= n_max_row;
            end
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + PW'(1);
            end else begin
                r_col <= r_col + PW'(1);
            end
        end
    end

endmodule

### design/abbc_queue.sv
module abbc_queue import abbc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_qstat o_stat,
    output t_job   o_head
);

    t_job           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_count;

    assign o_head          = r_mem[r_rd];
    assign o_stat.full     = (r_count == QCW'(QUEUE_DEPTH));
    assign o_stat.nonempty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
    end

endmodule

### design/abbc_back.sv
module abbc_back import abbc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qstat      i_stat,
    input  t_job        i_head,
    output logic        o_pop,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic        o_result_kind,
    output logic [15:0] o_color565,
    output logic [7:0]  o_alpha_out,
    output logic [11:0] o_box_left,
    output logic [11:0] o_box_top,
    output logic [12:0] o_box_width,
    output logic [12:0] o_box_height,
    output logic        o_box_empty,
    output logic        o_last_pixel
);

    logic        r_valid;
    logic        r_kind, r_empty, r_last;
    logic [15:0] r_color;
    logic [7:0]  r_alpha;
    logic [11:0] r_left, r_top;
    logic [12:0] r_width, r_height;
    logic        is_pix;

    assign is_pix = (i_head.kind == KIND_PIXEL);
    assign o_pop  = i_stat.nonempty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_head.kind;
            r_color  <= is_pix ? {i_head.rgb[23:19], i_head.rgb[15:10], i_head.rgb[7:3]}
                               : 16'd0;
            r_alpha  <= is_pix ? i_head.alpha : 8'd0;
            r_left   <= is_pix ? 12'd0 : i_head.left;
            r_top    <= is_pix ? 12'd0 : i_head.top;
            r_width  <= is_pix ? 13'd0 : i_head.width;
            r_height <= is_pix ? 13'd0 : i_head.height;
            r_empty  <= is_pix ? 1'b0 : i_head.empty;
            r_last   <= is_pix ? i_head.last : 1'b0;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_result_kind = r_kind;
    assign o_color565    = r_color;
    assign o_alpha_out   = r_alpha;
    assign o_box_left    = r_left;
    assign o_box_top     = r_top;
    assign o_box_width   = r_width;
    assign o_box_height  = r_height;
    assign o_box_empty   = r_empty;
    assign o_last_pixel  = r_last;

endmodule

### design/alpha_bbox_crop_rgb565_unit.sv
// Each result job is written into the queue, then popped into the output register.
// Throughput: one pixel word per cycle while input stall is low; a 4-word queue
// between the scan logic and the output register absorbs output stalls, and input
// stall rises when it fills or while a register write is presented.
// Reset (synchronous, active low): width and height 1, alpha from pixel bits,
// scan at column 0 row 0, box empty, queue and output register empty.
module alpha_bbox_crop_rgb565_unit import abbc_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_pixel_argb,
    input  logic [7:0]  i_alpha_sample,
    input  logic        i_pass_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [15:0] o_color565,
    output logic [7:0]  o_alpha_out,
    output logic [11:0] o_box_left,
    output logic [11:0] o_box_top,
    output logic [12:0] o_box_width,
    output logic [12:0] o_box_height,
    output logic        o_box_empty,
    output logic        o_last_pixel
);

    t_job   push_job, head_job;
    t_qstat qstat;
    logic   push, pop, accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = qstat.full || i_cfg_valid;
    assign accept      = i_in_valid && !o_in_stall;

    abbc_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_pixel_argb   (i_pixel_argb),
        .i_alpha_sample (i_alpha_sample),
        .i_pass_index   (i_pass_index),
        .o_push         (push),
        .o_job          (push_job)
    );

    abbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_stat  (qstat),
        .o_head  (head_job)
    );

    abbc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat        (qstat),
        .i_head        (head_job),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_color565    (o_color565),
        .o_alpha_out   (o_alpha_out),
        .o_box_left    (o_box_left),
        .o_box_top     (o_box_top),
        .o_box_width   (o_box_width),
        .o_box_height  (o_box_height),
        .o_box_empty   (o_box_empty),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

### design/abbc_checker.sv
module abbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_result_kind,
    input logic [15:0] o_color565,
    input logic [7:0]  o_alpha_out,
    input logic [12:0] o_box_width,
    input logic [12:0] o_box_height,
    input logic        o_box_empty,
    input logic        o_last_pixel
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_pixel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind) |-> (o_box_width == 13'd0 && !o_box_empty))
        else $error("pixel word carries box fields");

    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result_kind) |->
        (o_color565 == 16'd0 && o_alpha_out == 8'd0 && !o_last_pixel))
        else $error("box report carries pixel fields");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_box_empty) |-> (o_box_width == 13'd0 && o_box_height == 13'd0))
        else $error("empty box with nonzero size");

endmodule

bind alpha_bbox_crop_rgb565_unit abbc_checker u_abbc_checker (.*);
